// ----- hw/rtl/line_triangle_raster_max_fb_assert.svh -----
// Assertion macros used by the rasterizer back end RTL.
// Include with the bare file name; needs no other file.
`ifndef LINE_TRIANGLE_RASTER_MAX_FB_ASSERT_SVH
`define LINE_TRIANGLE_RASTER_MAX_FB_ASSERT_SVH

// Same-cycle implication.
`define LTR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ltr_pkg.sv -----
// Shared types and constants of the line and triangle rasterizer.
// No dependencies.
package ltr_pkg;

   localparam int FB_WIDTH    = 256;
   localparam int FB_HEIGHT   = 256;
   localparam int PIXELS      = FB_WIDTH * FB_HEIGHT;
   localparam int ADDR_W      = $clog2(PIXELS);
   localparam int XW          = $clog2(FB_WIDTH);
   localparam int YW          = $clog2(FB_HEIGHT);
   localparam int COUNT_W     = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
   localparam int CLEAR_N     = (PIXELS > 131071) ? 131071 : PIXELS;
   localparam int ORIGIN_W    = 12;
   localparam int REQ_W       = 112;
   localparam int RSP_W       = 56;

   localparam logic REG_ORIGIN_X = 1'b0;
   localparam logic REG_ORIGIN_Y = 1'b1;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_LINE  = 2'd2,
      OP_TRI   = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [11:0] ax;
      logic signed [11:0] ay;
      logic signed [11:0] bx;
      logic signed [11:0] by_coord;
      logic signed [11:0] cx;
      logic signed [11:0] cy;
      logic [31:0]        paint;
   } cmd_type;

endpackage

// ----- hw/rtl/line_triangle_raster_max_fb.sv -----
// Read fetches one pixel when it lies inside the buffer; clear writes every pixel;
// line and triangle read each pixel on the buffer, write paint where it is not
// below the stored value, and skip clipped pixels. Triangle setup sorts the vertices
// by y and divides slopes at one quotient bit a cycle. One command runs at a time and a
// result waiting on rsp_tready holds the next one. Reset clears the frame store in a
// pass with no item accepted; origin_x and origin_y reset to 128.
module line_triangle_raster_max_fb (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op, ax, ay, bx, by_coord, cx, cy, paint from bit 0 up; zero padded
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_value, written_count from bit 0 up; zero padded
   output logic [55:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [ltr_pkg::ORIGIN_W-1:0] origin_x_ff;
   logic [ltr_pkg::ORIGIN_W-1:0] origin_y_ff;
   logic                         accept_en;
   logic                         cmd_valid;
   logic                         cmd_ready;
   ltr_pkg::cmd_type             cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ltr_pkg::REG_ORIGIN_X) ? {20'd0, origin_x_ff}
                                                               : {20'd0, origin_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= 12'd128;
         origin_y_ff <= 12'd128;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == ltr_pkg::REG_ORIGIN_X) origin_x_ff <= csr_pwdata[11:0];
         else                                       origin_y_ff <= csr_pwdata[11:0];
      end
   end

   ltr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (accept_en),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   ltr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .accept_en  (accept_en),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/ltr_front.sv -----
// Front end: unpacks request items into commands and queues them.
// Depends on ltr_pkg.
module ltr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept_en,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // op, ax, ay, bx, by_coord, cx, cy, paint from bit 0 up; zero padded
   input  logic [ltr_pkg::REQ_W-1:0]    req_tdata,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output ltr_pkg::cmd_type             cmd
);

   ltr_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;
   ltr_pkg::cmd_type dec;
   logic             push;
   logic             pop;

   always_comb begin
      dec.op       = ltr_pkg::op_type'(req_tdata[1:0]);
      dec.ax       = req_tdata[13:2];
      dec.ay       = req_tdata[25:14];
      dec.bx       = req_tdata[37:26];
      dec.by_coord = req_tdata[49:38];
      dec.cx       = req_tdata[61:50];
      dec.cy       = req_tdata[73:62];
      dec.paint    = req_tdata[105:74];
   end

   assign req_tready = accept_en && (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ----- hw/rtl/ltr_back.sv -----
// Back end: sequencer that runs read, clear, line and triangle commands
// against the frame store and registers one result per command. Uses ltr_pkg.
`include "line_triangle_raster_max_fb_assert.svh"
module ltr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ltr_pkg::ORIGIN_W-1:0]    origin_x,
   input  logic [ltr_pkg::ORIGIN_W-1:0]    origin_y,
   output logic                            accept_en,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  ltr_pkg::cmd_type                cmd,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value, written_count from bit 0 up; zero padded
   output logic [ltr_pkg::RSP_W-1:0]       rsp_tdata
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_RD_CAP,
      ST_LN_STEEP, ST_LN_ORDER, ST_LN_INIT, ST_LN_POINT, ST_LN_STEP,
      ST_TR_SORT0, ST_TR_SORT1, ST_TR_SORT2,
      ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_END,
      ST_TR_INIT, ST_TR_ROW, ST_SPAN, ST_SPAN_NEXT, ST_TR_STEP,
      ST_PIX_RD, ST_PIX_WR, ST_DONE
   } state_type;

   localparam int AW = ltr_pkg::ADDR_W;
   localparam int XW = ltr_pkg::XW;
   localparam int YW = ltr_pkg::YW;

   logic [31:0] mem [ltr_pkg::PIXELS];
   logic [31:0] rd_data_ff;
   logic        we;

   state_type                   state_ff;
   state_type                   ret_ff;
   logic                        init_ff;
   logic [AW-1:0]               addr_ff;
   logic [31:0]                 paint_ff;
   logic [ltr_pkg::COUNT_W-1:0] cnt_ff;
   logic [31:0]                 rv_ff;
   logic signed [11:0]          vx_ff [3];
   logic signed [11:0]          vy_ff [3];
   // line walker
   logic                        steep_ff;
   logic signed [11:0]          lx_ff;
   logic signed [11:0]          ly_ff;
   logic signed [11:0]          lx2_ff;
   logic [12:0]                 dx_ff;
   logic [12:0]                 k_ff;
   logic                        dir_neg_ff;
   logic signed [15:0]          err_ff;
   // slope divider
   logic [1:0]                  div_idx_ff;
   logic [4:0]                  div_cnt_ff;
   logic [28:0]                 quo_ff;
   logic [14:0]                 rem_ff;
   logic [13:0]                 den_ff;
   logic                        neg_ff;
   logic signed [29:0]          slope_ff [3];
   // triangle walker
   logic signed [47:0]          e1_ff;
   logic signed [47:0]          e2_ff;
   logic signed [11:0]          ty_ff;
   logic [AW-1:0]               row_base_ff;
   logic [XW-1:0]               sx_ff;
   logic [XW-1:0]               ex_ff;
   // result register
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_rv_ff;
   logic [ltr_pkg::COUNT_W-1:0] rsp_cnt_ff;

   // combinational helpers
   logic signed [13:0] rd_x, rd_y;
   logic               rd_in;
   logic signed [12:0] ldx, ldy;
   logic [12:0]        ladx, lady;
   logic signed [12:0] odx, ody;
   logic signed [13:0] pl_x, pl_y;
   logic signed [13:0] px, py;
   logic               pt_in;
   logic signed [15:0] errn;
   logic signed [16:0] errn2;
   logic [1:0]         pa, pb;
   logic signed [12:0] div_dx;
   logic signed [12:0] div_dy;
   logic [14:0]        div_sh;
   logic [14:0]        div_diff;
   logic [47:0]        m1, m2;
   logic signed [31:0] i1, i2, lo, hi;
   logic signed [33:0] lo_o, hi_o, sx_c, ex_c;
   logic signed [13:0] ry;
   logic               ry_in;
   logic [ltr_pkg::COUNT_W-1:0] cnt_inc;

   assign we = (state_ff == ST_CLEAR) || (state_ff == ST_PIX_WR && paint_ff >= rd_data_ff);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr_ff] <= paint_ff;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_comb begin
      rd_x  = 14'(cmd.ax);
      rd_y  = 14'(cmd.ay);
      rd_in = (rd_x >= 0) && (rd_y >= 0) && (rd_x < $signed(14'(ltr_pkg::FB_WIDTH)))
              && (rd_y < $signed(14'(ltr_pkg::FB_HEIGHT)));

      ldx  = 13'(vx_ff[1]) - 13'(vx_ff[0]);
      ldy  = 13'(vy_ff[1]) - 13'(vy_ff[0]);
      ladx = ldx[12] ? 13'(-ldx) : 13'(ldx);
      lady = ldy[12] ? 13'(-ldy) : 13'(ldy);
      odx  = ldx;
      ody  = ldy;

      pl_x  = steep_ff ? 14'(ly_ff) : 14'(lx_ff);
      pl_y  = steep_ff ? 14'(lx_ff) : 14'(ly_ff);
      px    = pl_x + $signed({2'b00, origin_x});
      py    = pl_y + $signed({2'b00, origin_y});
      pt_in = (px >= 0) && (py >= 0) && (px < $signed(14'(ltr_pkg::FB_WIDTH)))
              && (py < $signed(14'(ltr_pkg::FB_HEIGHT)));

      errn  = err_ff + $signed({3'b000, k_ff});
      errn2 = {errn, 1'b0};

      case (div_idx_ff)
         2'd0:    begin pa = 2'd0; pb = 2'd1; end
         2'd1:    begin pa = 2'd1; pb = 2'd2; end
         default: begin pa = 2'd0; pb = 2'd2; end
      endcase
      div_dx   = 13'(vx_ff[pb]) - 13'(vx_ff[pa]);
      div_dy   = 13'(vy_ff[pb]) - 13'(vy_ff[pa]);
      div_sh   = {rem_ff[13:0], quo_ff[28]};
      div_diff = div_sh - {1'b0, den_ff};

      // Positions are truncated toward zero, not floored.
      m1 = e1_ff[47] ? 48'(-e1_ff) : 48'(e1_ff);
      m2 = e2_ff[47] ? 48'(-e2_ff) : 48'(e2_ff);
      i1 = e1_ff[47] ? -$signed(m1[47:16]) : $signed(m1[47:16]);
      i2 = e2_ff[47] ? -$signed(m2[47:16]) : $signed(m2[47:16]);
      lo = (e1_ff > e2_ff) ? i2 : i1;
      hi = (e1_ff > e2_ff) ? i1 : i2;
      lo_o = 34'(lo) + $signed({22'd0, origin_x});
      hi_o = 34'(hi) + $signed({22'd0, origin_x});
      sx_c = (lo_o < 0) ? 34'sd0 : lo_o;
      ex_c = (hi_o > $signed(34'(ltr_pkg::FB_WIDTH - 1))) ?
             $signed(34'(ltr_pkg::FB_WIDTH - 1)) : hi_o;
      ry    = 14'(ty_ff) + $signed({2'b00, origin_y});
      ry_in = (ry >= 0) && (ry < $signed(14'(ltr_pkg::FB_HEIGHT)));

      cnt_inc = (cnt_ff == ltr_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   end

   assign accept_en  = !init_ff;
   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cnt_ff, rsp_rv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         init_ff      <= 1'b1;
         addr_ff      <= '0;
         paint_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == AW'(ltr_pkg::PIXELS - 1)) begin
                  init_ff  <= 1'b0;
                  state_ff <= init_ff ? ST_IDLE : ST_DONE;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  paint_ff <= cmd.paint;
                  vx_ff[0] <= cmd.ax;
                  vy_ff[0] <= cmd.ay;
                  vx_ff[1] <= cmd.bx;
                  vy_ff[1] <= cmd.by_coord;
                  vx_ff[2] <= cmd.cx;
                  vy_ff[2] <= cmd.cy;
                  cnt_ff   <= (cmd.op == ltr_pkg::OP_CLEAR) ?
                              ltr_pkg::COUNT_W'(ltr_pkg::CLEAR_N) : '0;
                  rv_ff    <= '0;
                  case (cmd.op)
                     ltr_pkg::OP_READ: begin
                        if (rd_in) begin
                           addr_ff  <= AW'(rd_y[YW-1:0]) * AW'(ltr_pkg::FB_WIDTH)
                                       + AW'(rd_x[XW-1:0]);
                           state_ff <= ST_RD_WAIT;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     ltr_pkg::OP_CLEAR: begin
                        addr_ff  <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     ltr_pkg::OP_LINE: state_ff <= ST_LN_STEEP;
                     default:          state_ff <= ST_TR_SORT0;
                  endcase
               end
            end
            ST_RD_WAIT: state_ff <= ST_RD_CAP;
            ST_RD_CAP: begin
               rv_ff    <= rd_data_ff;
               state_ff <= ST_DONE;
            end
            ST_LN_STEEP: begin
               steep_ff <= (ladx < lady);
               if (ladx < lady) begin
                  vx_ff[0] <= vy_ff[0];
                  vy_ff[0] <= vx_ff[0];
                  vx_ff[1] <= vy_ff[1];
                  vy_ff[1] <= vx_ff[1];
               end
               state_ff <= ST_LN_ORDER;
            end
            ST_LN_ORDER: begin
               if (vx_ff[0] > vx_ff[1]) begin
                  vx_ff[0] <= vx_ff[1];
                  vy_ff[0] <= vy_ff[1];
                  vx_ff[1] <= vx_ff[0];
                  vy_ff[1] <= vy_ff[0];
               end
               state_ff <= ST_LN_INIT;
            end
            ST_LN_INIT: begin
               lx_ff      <= vx_ff[0];
               ly_ff      <= vy_ff[0];
               lx2_ff     <= vx_ff[1];
               dx_ff      <= 13'(odx);
               k_ff       <= ody[12] ? 13'(-ody) : 13'(ody);
               dir_neg_ff <= !(ody > 0);
               err_ff     <= '0;
               state_ff   <= ST_LN_POINT;
            end
            ST_LN_POINT: begin
               if (pt_in) begin
                  addr_ff  <= AW'(py[YW-1:0]) * AW'(ltr_pkg::FB_WIDTH) + AW'(px[XW-1:0]);
                  ret_ff   <= ST_LN_STEP;
                  state_ff <= ST_PIX_RD;
               end else begin
                  state_ff <= ST_LN_STEP;
               end
            end
            ST_LN_STEP: begin
               if (errn2 > $signed({4'b0000, dx_ff})) begin
                  ly_ff  <= dir_neg_ff ? ly_ff - 12'sd1 : ly_ff + 12'sd1;
                  err_ff <= errn - $signed({3'b000, dx_ff});
               end else begin
                  err_ff <= errn;
               end
               if (lx_ff == lx2_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  lx_ff    <= lx_ff + 12'sd1;
                  state_ff <= ST_LN_POINT;
               end
            end
            // The three compare-and-swaps order the vertices by y.
            ST_TR_SORT0, ST_TR_SORT2: begin
               if (vy_ff[0] > vy_ff[1]) begin
                  vx_ff[0] <= vx_ff[1];
                  vy_ff[0] <= vy_ff[1];
                  vx_ff[1] <= vx_ff[0];
                  vy_ff[1] <= vy_ff[0];
               end
               state_ff   <= (state_ff == ST_TR_SORT0) ? ST_TR_SORT1 : ST_DIV_LOAD;
               div_idx_ff <= 2'd0;
            end
            ST_TR_SORT1: begin
               if (vy_ff[1] > vy_ff[2]) begin
                  vx_ff[1] <= vx_ff[2];
                  vy_ff[1] <= vy_ff[2];
                  vx_ff[2] <= vx_ff[1];
                  vy_ff[2] <= vy_ff[1];
               end
               state_ff <= ST_TR_SORT2;
            end
            ST_DIV_LOAD: begin
               neg_ff     <= div_dx[12];
               quo_ff     <= {(div_dx[12] ? 13'(-div_dx) : 13'(div_dx)), 16'd0};
               rem_ff     <= '0;
               den_ff     <= 14'(div_dy) + 14'd1;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               if (!div_diff[14]) begin
                  rem_ff <= div_diff;
                  quo_ff <= {quo_ff[27:0], 1'b1};
               end else begin
                  rem_ff <= div_sh;
                  quo_ff <= {quo_ff[27:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 5'd28) state_ff <= ST_DIV_END;
            end
            ST_DIV_END: begin
               slope_ff[div_idx_ff] <= neg_ff ? -$signed({1'b0, quo_ff})
                                              : $signed({1'b0, quo_ff});
               div_idx_ff <= div_idx_ff + 1'b1;
               state_ff   <= (div_idx_ff == 2'd2) ? ST_TR_INIT : ST_DIV_LOAD;
            end
            ST_TR_INIT: begin
               e1_ff    <= {{20{vx_ff[0][11]}}, vx_ff[0], 16'd0};
               e2_ff    <= {{20{vx_ff[0][11]}}, vx_ff[0], 16'd0};
               ty_ff    <= vy_ff[0];
               state_ff <= ST_TR_ROW;
            end
            ST_TR_ROW: begin
               if (ry_in && sx_c <= ex_c) begin
                  row_base_ff <= AW'(ry[YW-1:0]) * AW'(ltr_pkg::FB_WIDTH);
                  sx_ff       <= sx_c[XW-1:0];
                  ex_ff       <= ex_c[XW-1:0];
                  state_ff    <= ST_SPAN;
               end else begin
                  state_ff <= ST_TR_STEP;
               end
            end
            ST_SPAN: begin
               addr_ff  <= row_base_ff + AW'(sx_ff);
               ret_ff   <= ST_SPAN_NEXT;
               state_ff <= ST_PIX_RD;
            end
            ST_SPAN_NEXT: begin
               if (sx_ff == ex_ff) begin
                  state_ff <= ST_TR_STEP;
               end else begin
                  sx_ff    <= sx_ff + 1'b1;
                  state_ff <= ST_SPAN;
               end
            end
            ST_TR_STEP: begin
               e1_ff <= e1_ff + 48'((ty_ff <= vy_ff[1]) ? slope_ff[0] : slope_ff[1]);
               e2_ff <= e2_ff + 48'(slope_ff[2]);
               if (ty_ff == vy_ff[2]) begin
                  state_ff <= ST_DONE;
               end else begin
                  ty_ff    <= ty_ff + 12'sd1;
                  state_ff <= ST_TR_ROW;
               end
            end
            ST_PIX_RD: state_ff <= ST_PIX_WR;
            ST_PIX_WR: begin
               if (paint_ff >= rd_data_ff) cnt_ff <= cnt_inc;
               state_ff <= ret_ff;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_rv_ff    <= rv_ff;
                  rsp_cnt_ff   <= cnt_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `LTR_ASSERT_IMPL(a_we_state, clock, reset, we, (state_ff == ST_CLEAR || state_ff == ST_PIX_WR), "frame store written outside a write state")
   `LTR_ASSERT_IMPL(a_span_order, clock, reset, state_ff == ST_SPAN, sx_ff <= ex_ff, "span start passed span end")
   `LTR_ASSERT_NEXT(a_pix_seq, clock, reset, state_ff == ST_PIX_RD, state_ff == ST_PIX_WR, "pixel read not followed by write check")

endmodule
